// ===== hdl/pcia_pkg.sv =====
// Types, constants and codes shared by the pair class id assigner.
package pcia_pkg;

    localparam int ID_W           = 12;
    localparam int LOG_DEPTH      = 4096;
    localparam int LOG_AW         = 12;
    localparam int PROD_W         = 2 * ID_W;
    localparam int TABLE_SIZE_DEF = 4096;
    localparam int CFG_IDX_W      = 1;

    localparam logic [ID_W-1:0] ID_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_DISTINCT  = 1'b0,
        REG_RIGHT_DISTINCT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_UPD,
        ST_WALK,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0] left_id;
        logic [ID_W-1:0] right_id;
        logic            last_site;
    } site_t;

    typedef struct packed {
        logic [ID_W-1:0] parent_id;
        logic            first_of_class;
        logic            repeats_used;
        logic            id_fault;
        logic [ID_W-1:0] distinct_count;
    } result_t;

endpackage

// ===== hdl/pair_class_id_assigner.sv =====
// Pair class id assigner: maps child class id pairs to dense parent ids.
//
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------
// site     | start, busy              | site_t: left_id, right_id, last_site
// result   | done (one-cycle strobe)  | result_t: parent_id .. distinct_count
// config   | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// An item passes through calc, table read and update before the done strobe,
// then goes back to idle; the pair table read-modify-write sets these steps.
// A last_site item that leaves ids open adds a cleanup walk over the log.
// After reset the table is cleared entry by entry with busy high.
// The receiver cannot stall; done is high for exactly one cycle and result holds after it.
module pair_class_id_assigner
    import pcia_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  site_t                site,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_idx_t             cfg_index,
    input  logic [ID_W-1:0]      cfg_data
);

    localparam int TBL_AW = $clog2(TABLE_SIZE);
    localparam logic [PROD_W-1:0] TBL_LIMIT = PROD_W'(TABLE_SIZE);
    localparam logic [TBL_AW-1:0] INIT_LAST = TBL_AW'(TABLE_SIZE - 1);

    logic [ID_W-1:0]   tbl_mem [TABLE_SIZE];
    logic [TBL_AW-1:0] log_mem [LOG_DEPTH];

    state_t            state_reg, state_next;
    logic [ID_W-1:0]   ld_reg, ld_next;
    logic [ID_W-1:0]   rd_reg, rd_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [ID_W-1:0]   walk_reg, walk_next;
    logic [TBL_AW-1:0] init_reg, init_next;
    logic              pend_reg, pend_next;
    logic              done_reg, done_next;

    site_t             site_reg;
    logic              use_reg;
    logic              fault_reg;
    logic [TBL_AW-1:0] idx_reg;
    result_t           result_reg, result_next;
    logic [ID_W-1:0]   tbl_rdata_reg;
    logic [TBL_AW-1:0] log_rdata_reg;

    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] idx_full;
    logic              use_calc;
    logic              fault_calc;

    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [ID_W-1:0]   tbl_wdata;
    logic              log_we;

    logic              act;
    logic              hit;
    logic              newc;
    logic [ID_W-1:0]   id_inc;
    logic [ID_W-1:0]   id_after;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        product  = PROD_W'(ld_reg) * PROD_W'(rd_reg);
        idx_full = PROD_W'(site_reg.left_id - ID_W'(1))
                 + PROD_W'(site_reg.right_id - ID_W'(1)) * PROD_W'(ld_reg);
        use_calc = (product != '0) && (product < TBL_LIMIT);
        fault_calc = use_calc && ((site_reg.left_id == '0) || (site_reg.left_id > ld_reg)
                               || (site_reg.right_id == '0) || (site_reg.right_id > rd_reg));
    end

    always_comb
    begin
        act      = use_reg && !fault_reg;
        hit      = (tbl_rdata_reg != '0);
        newc     = act && !hit && (next_id_reg != ID_MAX);
        id_inc   = next_id_reg + ID_W'(1);
        id_after = newc ? id_inc : next_id_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        ld_next      = ld_reg;
        rd_next      = rd_reg;
        next_id_next = next_id_reg;
        walk_next    = walk_reg;
        init_next    = init_reg;
        pend_next    = 1'b0;
        done_next    = 1'b0;
        result_next  = result_reg;
        tbl_we       = 1'b0;
        tbl_waddr    = idx_reg;
        tbl_wdata    = '0;
        log_we       = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEFT_DISTINCT:  ld_next = cfg_data;
                REG_RIGHT_DISTINCT: rd_next = cfg_data;
                default:            ld_next = ld_reg;
            endcase
        end

        unique case (state_reg)
            ST_INIT:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = init_reg;
                init_next = init_reg + TBL_AW'(1);
                if (init_reg == INIT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                tbl_we    = newc;
                tbl_waddr = idx_reg;
                tbl_wdata = id_inc;
                log_we    = newc;
                next_id_next = id_after;
                done_next = 1'b1;
                result_next.parent_id      = !act ? '0 : (hit ? tbl_rdata_reg
                                                              : (newc ? id_inc : '0));
                result_next.first_of_class = newc;
                result_next.repeats_used   = use_reg;
                result_next.id_fault       = fault_reg;
                result_next.distinct_count = use_reg ? id_after : '0;
                state_next = ST_IDLE;
                if (site_reg.last_site)
                begin
                    walk_next = '0;
                    if (id_after == '0)
                    begin
                        next_id_next = '0;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                pend_next = 1'b1;
                tbl_we    = pend_reg;
                tbl_waddr = log_rdata_reg;
                walk_next = walk_reg + ID_W'(1);
                if (walk_reg == next_id_reg - ID_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                tbl_we       = pend_reg;
                tbl_waddr    = log_rdata_reg;
                next_id_next = '0;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            ld_reg      <= '0;
            rd_reg      <= '0;
            next_id_reg <= '0;
            walk_reg    <= '0;
            init_reg    <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ld_reg      <= ld_next;
            rd_reg      <= rd_next;
            next_id_reg <= next_id_next;
            walk_reg    <= walk_next;
            init_reg    <= init_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            site_reg <= site;
        end
        if (state_reg == ST_CALC)
        begin
            use_reg   <= use_calc;
            fault_reg <= fault_calc;
            idx_reg   <= idx_full[TBL_AW-1:0];
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata_reg <= tbl_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (log_we)
        begin
            log_mem[next_id_reg] <= idx_reg;
        end
        log_rdata_reg <= log_mem[walk_reg];
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the pair class id assigner: directed and random sites checked against a predictor.
module tb_top
    import pcia_pkg::*;
();

    localparam int PHASES      = 16;
    localparam int PHASE_SITES = 83;
    localparam int STALL_LIMIT = 5 * (TABLE_SIZE_DEF + 8);
    localparam int END_LIMIT   = 4 * (TABLE_SIZE_DEF + 8);

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     start     = 1'b0;
    logic     busy;
    site_t    site      = '0;
    logic     done;
    result_t  result;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = REG_LEFT_DISTINCT;
    logic [ID_W-1:0] cfg_data = '0;

    pair_class_id_assigner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .site      (site),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    site_t   site_q[$];
    result_t parent_q[$];
    result_t want;

    logic [ID_W-1:0]   pair_ids   [TABLE_SIZE_DEF];
    logic [LOG_AW-1:0] opened_idx [LOG_DEPTH];
    int unsigned       ids_open  = 0;
    logic [ID_W-1:0]   left_cnt  = '0;
    logic [ID_W-1:0]   right_cnt = '0;

    int   errors     = 0;
    int   quiet      = 0;
    logic site_taken = 1'b0;
    int   gap_left   = 0;
    int   burst_left = 20;
    logic drain_hold = 1'b0;

    int unsigned sweep_left  [12];
    int unsigned sweep_right [12];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic result_t assign_parent(site_t s);
        result_t     r;
        int unsigned prod;
        int unsigned idx;
        int unsigned k;
        r    = '0;
        prod = left_cnt * right_cnt;
        r.repeats_used = (prod != 0) && (prod < TABLE_SIZE_DEF);
        if (r.repeats_used)
        begin
            if (s.left_id == 0 || s.left_id > left_cnt ||
                s.right_id == 0 || s.right_id > right_cnt)
            begin
                r.id_fault = 1'b1;
            end
            else
            begin
                idx = (s.left_id - 1) + (s.right_id - 1) * left_cnt;
                if (pair_ids[idx] == 0)
                begin
                    if (ids_open < ID_MAX)
                    begin
                        opened_idx[ids_open] = LOG_AW'(idx);
                        ids_open = ids_open + 1;
                        pair_ids[idx] = ID_W'(ids_open);
                        r.first_of_class = 1'b1;
                        r.parent_id = ID_W'(ids_open);
                    end
                end
                else
                begin
                    r.parent_id = pair_ids[idx];
                end
            end
            r.distinct_count = ID_W'(ids_open);
        end
        if (s.last_site)
        begin
            for (k = 0; k < ids_open; k++)
                pair_ids[opened_idx[k]] = '0;
            ids_open = 0;
        end
        return r;
    endfunction

    function automatic logic [ID_W-1:0] pick_id(int unsigned top);
        if (top == 0)
            return ID_W'($urandom_range(1, ID_MAX));
        if ($urandom_range(0, 1) == 1 && top > 8)
            return ID_W'($urandom_range(1, 8));
        return ID_W'($urandom_range(1, top));
    endfunction

    function automatic site_t pick_site(int unsigned lmax, int unsigned rmax);
        site_t       s;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        s.left_id  = ID_W'($urandom);
        s.right_id = ID_W'($urandom);
        if (roll < 92)
        begin
            s.left_id  = pick_id(lmax);
            s.right_id = pick_id(rmax);
        end
        if (roll >= 80 && roll < 92)
        begin
            case ($urandom_range(0, 3))
                0: s.left_id = '0;
                1: s.right_id = '0;
                2: if (lmax < ID_MAX) s.left_id = ID_W'($urandom_range(lmax + 1, ID_MAX));
                default: if (rmax < ID_MAX) s.right_id = ID_W'($urandom_range(rmax + 1, ID_MAX));
            endcase
        end
        s.last_site = ($urandom_range(0, 39) == 0);
        return s;
    endfunction

    function automatic void push_site(int unsigned l, int unsigned r, bit last);
        site_t s;
        s.left_id   = ID_W'(l);
        s.right_id  = ID_W'(r);
        s.last_site = last;
        site_q.push_back(s);
    endfunction

    task automatic write_reg(cfg_idx_t which, int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= ID_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (site_q.size() != 0 || start || parent_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Driver: bursts of sites with random gaps, occasional drain holds
    always @(negedge clk)
    begin
        if (rst_n && (site_taken || !start))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (drain_hold)
            begin
                if (parent_q.size() == 0)
                    drain_hold <= 1'b0;
                start <= 1'b0;
            end
            else if (site_q.size() != 0)
            begin
                site  <= site_q.pop_front();
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    drain_hold <= ($urandom_range(0, 7) == 0);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: track registers, check results, predict accepted sites
    always @(posedge clk)
    begin
        site_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LEFT_DISTINCT)
                    left_cnt = cfg_data;
                else
                    right_cnt = cfg_data;
            end
            if (done)
            begin
                if (parent_q.size() == 0)
                begin
                    $error("result with no site outstanding: %p", result);
                    errors++;
                end
                else
                begin
                    want = parent_q.pop_front();
                    if (result.parent_id !== want.parent_id)
                    begin
                        $error("parent_id: expected %0d, got %0d",
                               want.parent_id, result.parent_id);
                        errors++;
                    end
                    if (result.first_of_class !== want.first_of_class)
                    begin
                        $error("first_of_class: expected %0d, got %0d",
                               want.first_of_class, result.first_of_class);
                        errors++;
                    end
                    if (result.repeats_used !== want.repeats_used)
                    begin
                        $error("repeats_used: expected %0d, got %0d",
                               want.repeats_used, result.repeats_used);
                        errors++;
                    end
                    if (result.id_fault !== want.id_fault)
                    begin
                        $error("id_fault: expected %0d, got %0d",
                               want.id_fault, result.id_fault);
                        errors++;
                    end
                    if (result.distinct_count !== want.distinct_count)
                    begin
                        $error("distinct_count: expected %0d, got %0d",
                               want.distinct_count, result.distinct_count);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                parent_q.push_back(assign_parent(site));
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                quiet <= 0;
            end
            else if (quiet >= STALL_LIMIT)
            begin
                $display("[pair_class_id_assigner] ERROR");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    initial
    begin
        int p;
        int n;
        int unsigned l;
        int unsigned r;
        for (n = 0; n < TABLE_SIZE_DEF; n++)
            pair_ids[n] = '0;
        sweep_left  = '{0, 4095, 1, 4095, 1,    64, 64, 8, 0, 13, 2,    5};
        sweep_right = '{0, 4095, 1, 1,    4095, 64, 63, 8, 9, 17, 2047, 5};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Small table: new pairs, repeats, bad ids, cleanup and reuse
        settle();
        write_reg(REG_LEFT_DISTINCT, 3);
        write_reg(REG_RIGHT_DISTINCT, 5);
        push_site(1, 1, 0);
        push_site(1, 1, 0);
        push_site(3, 5, 0);
        push_site(0, 1, 0);
        push_site(4, 1, 0);
        push_site(1, 0, 0);
        push_site(1, 6, 0);
        push_site(4095, 4095, 0);
        push_site(2, 3, 0);
        push_site(3, 5, 1);
        push_site(3, 5, 0);
        push_site(3, 5, 1);

        // Compression off
        settle();
        write_reg(REG_LEFT_DISTINCT, 0);
        push_site(4095, 4095, 1);
        push_site(0, 0, 0);
        push_site(2, 3, 1);

        // Widest left side that still fits
        settle();
        write_reg(REG_LEFT_DISTINCT, 4095);
        write_reg(REG_RIGHT_DISTINCT, 1);
        push_site(4095, 1, 0);
        push_site(1, 1, 0);
        push_site(4095, 1, 0);
        push_site(4095, 2, 0);
        push_site(2048, 1, 1);

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            if (p < 12)
            begin
                l = sweep_left[p];
                r = sweep_right[p];
            end
            else
            begin
                l = $urandom_range(1, 40);
                r = $urandom_range(1, 40);
            end
            write_reg(REG_LEFT_DISTINCT, l);
            write_reg(REG_RIGHT_DISTINCT, r);
            repeat (PHASE_SITES) site_q.push_back(pick_site(l, r));
        end

        while (site_q.size() != 0 || start)
            @(posedge clk);
        n = 0;
        while (parent_q.size() != 0 && n < END_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (16) @(posedge clk);
        if (parent_q.size() != 0)
        begin
            $error("%0d results never arrived", parent_q.size());
            errors++;
        end
        if (errors == 0)
            $display("[pair_class_id_assigner] OK");
        else
            $display("[pair_class_id_assigner] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pcia_pkg.sv
hdl/pair_class_id_assigner.sv
dv/tb_top.sv
